FILE: hdl/owik_pkg.sv
// shared constants for the omni-wheel inverse kinematics block
`default_nettype none
package owik_pkg;

	// default sizes of the quarter-wave sine table
	localparam int SINE_TABLE_DEPTH_DEF = 256;
	localparam int SINE_WIDTH_DEF = 16;

	// pi/2 in q2.30, start of the taylor series for the table entries
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// binary angles, 65536 per turn
	localparam logic [15:0] ANG_30 = 16'd5461;
	localparam logic [15:0] ANG_45 = 16'd8192;
	localparam logic [15:0] ANG_60 = 16'd10923;
	localparam logic [15:0] ANG_90 = 16'd16384;

	// wheel layouts
	localparam logic [1:0] LAYOUT_X4 = 2'd0;
	localparam logic [1:0] LAYOUT_CORNER3 = 2'd1;
	localparam logic [1:0] LAYOUT_EDGE3 = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_LAYOUT = 2'd0;
	localparam logic [1:0] CFG_RADIUS = 2'd1;
	localparam logic [1:0] CFG_SCALE = 2'd2;

	localparam int CFG_DATA_W = 24;
	localparam int RADIUS_W = 16;
	localparam int SCALE_W = 24;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd256;

	localparam int VEL_W = 16;
	localparam int SPEED_W = 24;
	localparam logic signed [SPEED_W-1:0] SPEED_MAX = 24'sh7FFFFF;
	localparam logic signed [SPEED_W-1:0] SPEED_MIN = 24'sh800000;

	localparam int LATENCY = 6;

endpackage
`default_nettype wire

FILE: hdl/omni_wheel_inverse_kinematics.sv
// top level: pipelined inverse kinematics for three- and four-wheel omni chassis
`default_nettype none
// takes one velocity command per clock while busy is low and returns the wheel speeds
// of each command on done, in request order, through the registered datapath: angle add,
// sine table read, coefficient multipliers, sum and rounding, gain multiplier, saturation
// into the output register; nothing stalls, so busy is high only while reset is applied
// and in the first cycle after it; results are shown for one cycle only and must be
// taken then; cfg_ready is always high and registers should be written only while no
// request is in flight
module omni_wheel_inverse_kinematics #(
	parameter int SINE_TABLE_DEPTH = owik_pkg::SINE_TABLE_DEPTH_DEF,
	parameter int SINE_WIDTH = owik_pkg::SINE_WIDTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic signed [owik_pkg::VEL_W-1:0]     vel_x,
	input  wire logic signed [owik_pkg::VEL_W-1:0]     vel_y,
	input  wire logic signed [owik_pkg::VEL_W-1:0]     spin_rate,
	input  wire logic [15:0]                           heading,
	output logic                                       done,
	output logic signed [owik_pkg::SPEED_W-1:0]        wheel_speed_a,
	output logic signed [owik_pkg::SPEED_W-1:0]        wheel_speed_b,
	output logic signed [owik_pkg::SPEED_W-1:0]        wheel_speed_c,
	output logic signed [owik_pkg::SPEED_W-1:0]        wheel_speed_d,
	output logic                                       saturated,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [1:0]                            cfg_index,
	input  wire logic [owik_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int SC_W = 14 + IDX_W;
	localparam int MAG_W = SINE_WIDTH - 1;
	localparam int PX_W = SINE_WIDTH + owik_pkg::VEL_W;
	localparam int RWP_W = owik_pkg::RADIUS_W + 1 + owik_pkg::VEL_W;
	localparam int SUM_W = SINE_WIDTH + 34;
	localparam int T_SHIFT = SINE_WIDTH + 7;
	localparam int T_W = SUM_W - T_SHIFT;
	localparam int PROD_W = T_W + owik_pkg::SCALE_W + 1;
	localparam int RES_W = PROD_W - 28;
	localparam logic signed [SUM_W-1:0] T_ROUND = SUM_W'(1) <<< (T_SHIFT - 1);
	localparam logic signed [PROD_W-1:0] R_ROUND = PROD_W'(1) <<< 27;

	typedef logic [MAG_W-1:0] rom_t [0:SINE_TABLE_DEPTH];

	// first quadrant of sine, series in q2.30 then scaled to the table amplitude
	function automatic rom_t build_rom();
		rom_t rom;
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] amp;
		logic signed [63:0] s;
		amp = (64'd1 << (SINE_WIDTH - 1)) - 64'd1;
		for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
			x = (64'(k) * owik_pkg::HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
			term = x;
			s = $signed(x);
			for (int n = 1; n <= 8; n++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				case (n)
					1: term = term / 64'd6;
					2: term = term / 64'd20;
					3: term = term / 64'd42;
					4: term = term / 64'd72;
					5: term = term / 64'd110;
					6: term = term / 64'd156;
					7: term = term / 64'd210;
					8: term = term / 64'd272;
					default: term = term;
				endcase
				if (n % 2 == 1) s = s - $signed(term);
				else s = s + $signed(term);
			end
			if (s < 0) s = 64'sd0;
			if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
			rom[k] = MAG_W'((($unsigned(s) * amp) + (64'd1 << 29)) >> 30);
		end
		return rom;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	function automatic logic signed [SINE_WIDTH-1:0] sin_lookup(input logic [15:0] ang);
		logic [SC_W-1:0] scaled;
		logic [IDX_W-1:0] idx;
		logic [MAG_W-1:0] mag;
		scaled = SC_W'(ang[13:0]) * SC_W'(SINE_TABLE_DEPTH) + SC_W'(8192);
		idx = scaled[14 +: IDX_W];
		if (idx > IDX_W'(SINE_TABLE_DEPTH)) idx = IDX_W'(SINE_TABLE_DEPTH);
		// odd quadrants read the table mirrored, the upper half negates
		mag = ang[14] ? SINE_ROM[IDX_W'(SINE_TABLE_DEPTH) - idx] : SINE_ROM[idx];
		return ang[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

	// configuration
	logic [1:0] layout_q;
	logic [owik_pkg::RADIUS_W-1:0] radius_q;
	logic [owik_pkg::SCALE_W-1:0] scale_q;
	logic busy_q;

	assign cfg_ready = 1'b1;
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q <= owik_pkg::LAYOUT_X4;
			radius_q <= '0;
			scale_q <= owik_pkg::SCALE_RESET;
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					owik_pkg::CFG_LAYOUT: layout_q <= cfg_data[1:0];
					owik_pkg::CFG_RADIUS: radius_q <= cfg_data[owik_pkg::RADIUS_W-1:0];
					owik_pkg::CFG_SCALE: scale_q <= cfg_data[owik_pkg::SCALE_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// pipeline registers
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [15:0] ang_s1 [3];
	logic signed [owik_pkg::VEL_W-1:0] vx_s1, vy_s1, w_s1;
	logic [1:0] layout_s1;

	logic signed [SINE_WIDTH-1:0] sin_s2 [3];
	logic signed [SINE_WIDTH-1:0] cos_s2 [3];
	logic signed [owik_pkg::VEL_W-1:0] vx_s2, vy_s2, w_s2;
	logic [1:0] layout_s2;

	logic signed [PX_W-1:0] px_s3 [4];
	logic signed [PX_W-1:0] py_s3 [4];
	logic signed [RWP_W-1:0] rw_s3;
	logic [3:0] mask_s3;

	logic signed [T_W-1:0] t_s4 [4];
	logic [3:0] mask_s4;

	logic signed [PROD_W-1:0] prod_s5 [4];
	logic [3:0] mask_s5;

	logic signed [owik_pkg::SPEED_W-1:0] speed_q [4];
	logic sat_q;
	logic done_q;

	// combinational between stages
	logic [15:0] ang0;
	logic signed [SINE_WIDTH-1:0] kx [4];
	logic signed [SINE_WIDTH-1:0] ky [4];
	logic [3:0] mask_n;
	logic signed [SUM_W-1:0] sum_n [4];
	logic signed [PROD_W-1:0] round_n [4];
	logic signed [RES_W-1:0] res_n [4];
	logic signed [owik_pkg::SPEED_W-1:0] speed_n [4];
	logic [3:0] clip_n;

	// the x layout only needs heading - 45deg: the other diagonal is a quarter turn on
	always_comb begin
		ang0 = heading;
		if (layout_q == owik_pkg::LAYOUT_X4) ang0 = heading - owik_pkg::ANG_45;
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			kx[i] = '0;
			ky[i] = '0;
		end
		mask_n = 4'b0000;
		case (layout_s2)
			owik_pkg::LAYOUT_X4: begin
				mask_n = 4'b1111;
				kx[0] = -sin_s2[0]; ky[0] = cos_s2[0];
				kx[1] = -cos_s2[0]; ky[1] = -sin_s2[0];
				kx[2] = sin_s2[0];  ky[2] = -cos_s2[0];
				kx[3] = cos_s2[0];  ky[3] = sin_s2[0];
			end
			owik_pkg::LAYOUT_CORNER3: begin
				mask_n = 4'b0111;
				kx[0] = -sin_s2[0]; ky[0] = cos_s2[0];
				kx[1] = -cos_s2[1]; ky[1] = -sin_s2[1];
				kx[2] = sin_s2[2];  ky[2] = -cos_s2[2];
			end
			owik_pkg::LAYOUT_EDGE3: begin
				mask_n = 4'b0111;
				kx[0] = -cos_s2[0]; ky[0] = -sin_s2[0];
				kx[1] = sin_s2[1];  ky[1] = -cos_s2[1];
				kx[2] = cos_s2[2];  ky[2] = sin_s2[2];
			end
			default: mask_n = 4'b0000;
		endcase
	end

	// round half up is an add and an arithmetic shift
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sum_n[i] = ((SUM_W'(px_s3[i]) + SUM_W'(py_s3[i])) <<< 16)
				+ (SUM_W'(rw_s3) <<< (SINE_WIDTH - 1)) + T_ROUND;
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			round_n[i] = (prod_s5[i] + R_ROUND) >>> 28;
			res_n[i] = RES_W'(round_n[i]);
			speed_n[i] = owik_pkg::SPEED_W'(res_n[i]);
			clip_n[i] = 1'b0;
			if (res_n[i] > RES_W'(owik_pkg::SPEED_MAX)) begin
				speed_n[i] = owik_pkg::SPEED_MAX;
				clip_n[i] = 1'b1;
			end else if (res_n[i] < RES_W'(owik_pkg::SPEED_MIN)) begin
				speed_n[i] = owik_pkg::SPEED_MIN;
				clip_n[i] = 1'b1;
			end
			if (!mask_s5[i]) begin
				speed_n[i] = '0;
				clip_n[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			done_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				speed_q[i] <= '0;
			end
			sat_q <= 1'b0;
		end else begin
			valid_s1 <= start && !busy_q;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			done_q <= valid_s5;
			// output payload only moves with a result so it holds between strobes
			if (valid_s5) begin
				for (int i = 0; i < 4; i++) begin
					speed_q[i] <= speed_n[i];
				end
				sat_q <= |clip_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		ang_s1[0] <= ang0;
		ang_s1[1] <= heading + owik_pkg::ANG_30;
		ang_s1[2] <= heading + owik_pkg::ANG_60;
		vx_s1 <= vel_x;
		vy_s1 <= vel_y;
		w_s1 <= spin_rate;
		layout_s1 <= layout_q;

		for (int j = 0; j < 3; j++) begin
			sin_s2[j] <= sin_lookup(ang_s1[j]);
			cos_s2[j] <= sin_lookup(ang_s1[j] + owik_pkg::ANG_90);
		end
		vx_s2 <= vx_s1;
		vy_s2 <= vy_s1;
		w_s2 <= w_s1;
		layout_s2 <= layout_s1;

		for (int i = 0; i < 4; i++) begin
			px_s3[i] <= kx[i] * vx_s2;
			py_s3[i] <= ky[i] * vy_s2;
		end
		rw_s3 <= $signed({1'b0, radius_q}) * w_s2;
		mask_s3 <= mask_n;

		for (int i = 0; i < 4; i++) begin
			t_s4[i] <= T_W'(sum_n[i] >>> T_SHIFT);
		end
		mask_s4 <= mask_s3;

		for (int i = 0; i < 4; i++) begin
			prod_s5[i] <= t_s4[i] * $signed({1'b0, scale_q});
		end
		mask_s5 <= mask_s4;
	end

	assign done = done_q;
	assign wheel_speed_a = speed_q[0];
	assign wheel_speed_b = speed_q[1];
	assign wheel_speed_c = speed_q[2];
	assign wheel_speed_d = speed_q[3];
	assign saturated = sat_q;

endmodule
`default_nettype wire

FILE: hdl/owik_checker.sv
// port checker for the omni-wheel inverse kinematics block and its bind
`default_nettype none
module owik_checker (
	input wire logic                                  clk,
	input wire logic                                  arst_n,
	input wire logic                                  start,
	input wire logic                                  busy,
	input wire logic signed [owik_pkg::VEL_W-1:0]     vel_x,
	input wire logic signed [owik_pkg::VEL_W-1:0]     vel_y,
	input wire logic signed [owik_pkg::VEL_W-1:0]     spin_rate,
	input wire logic [15:0]                           heading,
	input wire logic                                  done,
	input wire logic signed [owik_pkg::SPEED_W-1:0]   wheel_speed_a,
	input wire logic signed [owik_pkg::SPEED_W-1:0]   wheel_speed_b,
	input wire logic signed [owik_pkg::SPEED_W-1:0]   wheel_speed_c,
	input wire logic signed [owik_pkg::SPEED_W-1:0]   wheel_speed_d,
	input wire logic                                  saturated,
	input wire logic                                  cfg_valid,
	input wire logic                                  cfg_ready,
	input wire logic [1:0]                            cfg_index,
	input wire logic [owik_pkg::CFG_DATA_W-1:0]       cfg_data
);

	// every result belongs to an earlier accepted request
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, owik_pkg::LATENCY))
		else $error("result without a matching request");

	// once out of reset the pipeline never refuses a request
	a_busy_stays_low: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy raised after reset");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> ($stable(wheel_speed_a) && $stable(wheel_speed_b)
			&& $stable(wheel_speed_c) && $stable(wheel_speed_d) && $stable(saturated)))
		else $error("result payload moved without a strobe");

	// a clipped result must show at least one wheel at a rail
	a_sat_at_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |->
			(wheel_speed_a == owik_pkg::SPEED_MAX || wheel_speed_a == owik_pkg::SPEED_MIN
			|| wheel_speed_b == owik_pkg::SPEED_MAX || wheel_speed_b == owik_pkg::SPEED_MIN
			|| wheel_speed_c == owik_pkg::SPEED_MAX || wheel_speed_c == owik_pkg::SPEED_MIN
			|| wheel_speed_d == owik_pkg::SPEED_MAX || wheel_speed_d == owik_pkg::SPEED_MIN))
		else $error("saturated flag without a clipped wheel");

endmodule

bind omni_wheel_inverse_kinematics owik_checker u_owik_checker (.*);
`default_nettype wire

FILE: bench/testbench.sv
// self-checking bench for the omni-wheel inverse kinematics block
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import owik_pkg::*;

	localparam int ROM_DEPTH = SINE_TABLE_DEPTH_DEF;
	localparam int ROM_WIDTH = SINE_WIDTH_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [1:0] LAYOUT_UNUSED = 2'd3;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic signed [SPEED_W-1:0] a;
		logic signed [SPEED_W-1:0] b;
		logic signed [SPEED_W-1:0] c;
		logic signed [SPEED_W-1:0] d;
		logic                      sat;
	} wheel_set_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [VEL_W-1:0] vel_x = '0;
	logic signed [VEL_W-1:0] vel_y = '0;
	logic signed [VEL_W-1:0] spin_rate = '0;
	logic [15:0] heading = '0;
	logic done;
	logic signed [SPEED_W-1:0] wheel_speed_a;
	logic signed [SPEED_W-1:0] wheel_speed_b;
	logic signed [SPEED_W-1:0] wheel_speed_c;
	logic signed [SPEED_W-1:0] wheel_speed_d;
	logic saturated;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor copy of the registers
	logic [1:0] layout_now = LAYOUT_X4;
	logic [RADIUS_W-1:0] radius_now = '0;
	logic [SCALE_W-1:0] scale_now = SCALE_RESET;

	int sine_rom [0:ROM_DEPTH];
	wheel_set_t speeds_due [$];
	int errors = 0;
	int cycles = 0;
	int burst_left = 0;

	omni_wheel_inverse_kinematics dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.vel_x(vel_x), .vel_y(vel_y), .spin_rate(spin_rate), .heading(heading),
		.done(done), .wheel_speed_a(wheel_speed_a), .wheel_speed_b(wheel_speed_b),
		.wheel_speed_c(wheel_speed_c), .wheel_speed_d(wheel_speed_d),
		.saturated(saturated), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// quarter-wave table, taylor series of sin in q2.30
	function automatic void fill_sine_rom();
		longint unsigned amp, x, term;
		longint s;
		for (int k = 0; k <= ROM_DEPTH; k++) begin
			amp = (64'd1 << (ROM_WIDTH - 1)) - 64'd1;
			x = (longint'(k) * HALF_PI_Q30) / ROM_DEPTH;
			term = x;
			s = longint'(x);
			for (int n = 1; n <= 8; n++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = term / longint'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) s = s - longint'(term);
				else s = s + longint'(term);
			end
			if (s < 0) s = 0;
			if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
			sine_rom[k] = int'((longint'(s) * amp + (64'd1 << 29)) >> 30);
		end
	endfunction

	function automatic int sine_of(logic [15:0] ang);
		int i;
		int v;
		i = (int'(ang[13:0]) * ROM_DEPTH + 8192) >> 14;
		if (i > ROM_DEPTH) i = ROM_DEPTH;
		v = ang[14] ? sine_rom[ROM_DEPTH - i] : sine_rom[i];
		return ang[15] ? -v : v;
	endfunction

	function automatic int cosine_of(logic [15:0] ang);
		logic [15:0] shifted;
		shifted = ang + ANG_90;
		return sine_of(shifted);
	endfunction

	// unclamped rpm of one wheel; both roundings are half up, i.e. floor after adding half
	function automatic longint wheel_rpm(int kx, int ky, longint vx, longint vy, longint w);
		longint s;
		longint t;
		s = (longint'(kx) * vx + longint'(ky) * vy) * 65536
			+ longint'(radius_now) * w * (64'sd1 <<< (ROM_WIDTH - 1));
		t = (s + (64'sd1 <<< (ROM_WIDTH + 6))) >>> (ROM_WIDTH + 7);
		return (t * longint'(scale_now) + (64'sd1 <<< 27)) >>> 28;
	endfunction

	function automatic wheel_set_t predict_wheel_speeds(logic signed [15:0] vx,
		logic signed [15:0] vy, logic signed [15:0] w, logic [15:0] h);
		int kx [4];
		int ky [4];
		int wheels;
		longint raw;
		logic [15:0] p, q, h30, h60;
		logic signed [SPEED_W-1:0] spd [4];
		wheel_set_t res;
		p = h - ANG_45;
		q = h + ANG_45;
		h30 = h + ANG_30;
		h60 = h + ANG_60;
		wheels = 0;
		for (int j = 0; j < 4; j++) begin
			kx[j] = 0;
			ky[j] = 0;
			spd[j] = '0;
		end
		case (layout_now)
			LAYOUT_X4: begin
				wheels = 4;
				kx[0] = -sine_of(p); ky[0] = cosine_of(p);
				kx[1] = -sine_of(q); ky[1] = cosine_of(q);
				kx[2] = sine_of(p);  ky[2] = -cosine_of(p);
				kx[3] = sine_of(q);  ky[3] = -cosine_of(q);
			end
			LAYOUT_CORNER3: begin
				wheels = 3;
				kx[0] = -sine_of(h);     ky[0] = cosine_of(h);
				kx[1] = -cosine_of(h30); ky[1] = -sine_of(h30);
				kx[2] = sine_of(h60);    ky[2] = -cosine_of(h60);
			end
			LAYOUT_EDGE3: begin
				wheels = 3;
				kx[0] = -cosine_of(h);  ky[0] = -sine_of(h);
				kx[1] = sine_of(h30);   ky[1] = -cosine_of(h30);
				kx[2] = cosine_of(h60); ky[2] = sine_of(h60);
			end
			default: wheels = 0;   // unused layout drives every wheel to zero
		endcase
		res.sat = 1'b0;
		for (int j = 0; j < wheels; j++) begin
			raw = wheel_rpm(kx[j], ky[j], vx, vy, w);
			if (raw > longint'(SPEED_MAX)) begin
				raw = SPEED_MAX;
				res.sat = 1'b1;
			end
			if (raw < longint'(SPEED_MIN)) begin
				raw = SPEED_MIN;
				res.sat = 1'b1;
			end
			spd[j] = raw[SPEED_W-1:0];
		end
		res.a = spd[0];
		res.b = spd[1];
		res.c = spd[2];
		res.d = spd[3];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch at cycle %0d, %s: got %0d, expected %0d", cycles, what, got, want);
		errors++;
	endtask

	// result checker, samples on the edge that ends the strobe cycle
	always @(posedge clk) begin
		wheel_set_t want;
		if (arst_n && done) begin
			if (speeds_due.size() == 0) begin
				report_mismatch("result with no request pending", 1, 0);
			end else begin
				want = speeds_due.pop_front();
				if (wheel_speed_a !== want.a) report_mismatch("wheel_speed_a", wheel_speed_a, want.a);
				if (wheel_speed_b !== want.b) report_mismatch("wheel_speed_b", wheel_speed_b, want.b);
				if (wheel_speed_c !== want.c) report_mismatch("wheel_speed_c", wheel_speed_c, want.c);
				if (wheel_speed_d !== want.d) report_mismatch("wheel_speed_d", wheel_speed_d, want.d);
				if (saturated !== want.sat) report_mismatch("saturated", saturated, want.sat);
			end
		end
	end

	task automatic send_command(input logic signed [15:0] vx, input logic signed [15:0] vy,
		input logic signed [15:0] w, input logic [15:0] h);
		start <= 1'b1;
		vel_x <= vx;
		vel_y <= vy;
		spin_rate <= w;
		heading <= h;
		do @(posedge clk); while (busy);
		speeds_due.push_back(predict_wheel_speeds(vx, vy, w, h));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(0, 12);
		end
	endtask

	// stop sending and let every request in flight come out
	task automatic settle_block();
		start <= 1'b0;
		while (speeds_due.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_LAYOUT: layout_now = value[1:0];
			CFG_RADIUS: radius_now = value[RADIUS_W-1:0];
			CFG_SCALE:  scale_now = value[SCALE_W-1:0];
			default: ;   // index past the register list is ignored
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_chassis(input logic [1:0] layout, input logic [RADIUS_W-1:0] radius,
		input logic [SCALE_W-1:0] scale);
		settle_block();
		// upper data bits are noise for the layout register
		write_register(CFG_LAYOUT, {22'($urandom_range(0, 4194303)), layout});
		write_register(CFG_RADIUS, {8'($urandom), radius});
		write_register(CFG_SCALE, scale);
	endtask

	function automatic logic signed [15:0] pick_velocity();
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sh0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_heading();
		logic [15:0] h;
		h = 16'($urandom);
		// some headings sit near a quadrant edge, where the table lookup turns round
		if ($urandom_range(0, 5) == 0)
			h = {h[15:14], 14'h0000} + 16'($urandom_range(0, 6)) - 16'd3;
		return h;
	endfunction

	task automatic test_reset_values();
		send_command(16'sh0000, 16'sh0000, 16'sh0000, 16'h0000);
		send_command(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'h0000);
		send_command(16'sh8000, 16'sh7FFF, 16'sh8000, 16'hFFFF);
	endtask

	task automatic test_heading_quadrants();
		set_chassis(LAYOUT_X4, 16'h4000, 24'd300000);
		send_command(16'sh1000, 16'sh0800, 16'sh0400, 16'h3FFF);
		send_command(16'sh1000, 16'sh0800, 16'sh0400, 16'h4000);
		send_command(16'sh1000, 16'sh0800, 16'sh0400, 16'h8000);
		send_command(16'sh1000, 16'sh0800, 16'sh0400, 16'hC000);
	endtask

	task automatic test_layout_extremes();
		logic [1:0] layouts [3];
		layouts = '{LAYOUT_X4, LAYOUT_CORNER3, LAYOUT_EDGE3};
		foreach (layouts[n]) begin
			set_chassis(layouts[n], 16'hFFFF, 24'hFFFFFF);
			send_command(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'h2000);
			send_command(16'sh8000, 16'sh8000, 16'sh8000, 16'hE000);
			send_command(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'h6000);
		end
		set_chassis(LAYOUT_X4, 16'hFFFF, 24'h000000);
		send_command(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'h1234);
	endtask

	task automatic test_unused_layout();
		set_chassis(LAYOUT_UNUSED, 16'hFFFF, 24'hFFFFFF);
		send_command(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'h5555);
		send_command(16'sh8000, 16'sh7FFF, 16'sh8000, 16'hAAAA);
	endtask

	task automatic test_unused_index();
		set_chassis(LAYOUT_CORNER3, 16'h8000, 24'd65536);
		write_register(CFG_UNUSED, CFG_DATA_W'($urandom));
		send_command(16'sh2000, 16'shE000, 16'sh1000, 16'h3000);
		send_command(16'sh7FFF, 16'sh8000, 16'sh8000, 16'hBFFF);
	endtask

	task automatic test_random_commands();
		logic [1:0] layout;
		logic [RADIUS_W-1:0] radius;
		logic [SCALE_W-1:0] scale;
		for (int phase = 0; phase < 10; phase++) begin
			layout = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 7) == 0 ? 3 : $urandom_range(0, 2));
			radius = 16'($urandom);
			scale = 24'($urandom);
			if (phase == 1) begin
				radius = '0;
				scale = '0;
			end else if (phase == 2 || phase == 5) begin
				radius = '1;
				scale = '1;
			end
			set_chassis(layout, radius, scale);
			repeat (100)
				send_command(pick_velocity(), pick_velocity(), pick_velocity(), pick_heading());
		end
	endtask

	initial begin
		fill_sine_rom();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_heading_quadrants();
		test_layout_extremes();
		test_unused_layout();
		test_unused_index();
		test_random_commands();
		settle_block();
		repeat (LATENCY + 4) @(posedge clk);
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
`default_nettype wire

FILE: filelist.f
hdl/owik_pkg.sv
hdl/omni_wheel_inverse_kinematics.sv
hdl/owik_checker.sv
bench/testbench.sv
